### src/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg: shared types and codes for the line pixel stepper
// Status and function codes, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package lps_pkg;

   localparam int END_BITS      = 16;   // endpoint coordinate width (signed)
   localparam int COLOR_IN_BITS = 8;    // color index width on the input word
   localparam int SIZE_BITS     = 13;   // frame size register width
   localparam int STATUS_BITS   = 3;
   localparam int CSR_IDX_BITS  = 2;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_PIXEL    = 3'd0,
      ST_ACCEPTED = 3'd1,
      ST_REJECTED = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_IDLE     = 3'd4
   } lps_status_type;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FB_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FB_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_TOP = 2'd2;

   localparam logic [SIZE_BITS-1:0] FB_WIDTH_RESET  = 13'd320;
   localparam logic [SIZE_BITS-1:0] FB_HEIGHT_RESET = 13'd240;

   typedef struct packed {
      logic [SIZE_BITS-1:0] fb_width;
      logic [SIZE_BITS-1:0] fb_height;
      logic                 origin_top;
   } lps_cfg_type;

endpackage

### src/lps_engine.sv
// ----------------------------------------------------------------------------
// lps_engine: line setup and per-pixel stepping
// Holds the line state. The result for the presented word is combinational;
// state advances when fire is high.
// ----------------------------------------------------------------------------
module lps_engine #(
   parameter int COORD_BITS = 12,
   parameter int COLOR_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   fire,
   input  lps_pkg::lps_cfg_type                   cfg,
   input  logic                                   item_func,
   input  logic signed [lps_pkg::END_BITS-1:0]    item_x_start,
   input  logic signed [lps_pkg::END_BITS-1:0]    item_y_start,
   input  logic signed [lps_pkg::END_BITS-1:0]    item_x_end,
   input  logic signed [lps_pkg::END_BITS-1:0]    item_y_end,
   input  logic [lps_pkg::COLOR_IN_BITS-1:0]      item_color,
   output logic [lps_pkg::STATUS_BITS-1:0]        res_status,
   output logic [COORD_BITS-1:0]                  res_x,
   output logic [COORD_BITS-1:0]                  res_y,
   output logic [COLOR_BITS-1:0]                  res_color,
   output logic                                   res_last
);

   localparam int WB = lps_pkg::END_BITS + 2;        // room for the y flip
   localparam int EXT = WB - lps_pkg::END_BITS;
   localparam int SZ_EXT = WB - lps_pkg::SIZE_BITS;
   localparam logic [WB-1:0] LIMIT = WB'(1) << COORD_BITS;

   function automatic logic in_range(input logic signed [WB-1:0] v,
                                     input logic [WB-1:0] lim);
      return !v[WB-1] && ($unsigned(v) < lim);
   endfunction

   // line state
   logic [COORD_BITS-1:0]       cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]       cur_y_ff, cur_y_in;
   logic signed [COORD_BITS:0]  err_ff, err_in;
   logic [COORD_BITS-1:0]       minor_ff, minor_in;
   logic [COORD_BITS-1:0]       major_ff, major_in;
   logic [COORD_BITS-1:0]       left_ff, left_in;
   logic                        major_x_ff, major_x_in;
   logic [1:0]                  dir_x_ff, dir_x_in;
   logic [1:0]                  dir_y_ff, dir_y_in;
   logic [COLOR_BITS-1:0]       color_ff, color_in;
   logic                        active_ff, active_in;

   // setup path
   logic signed [WB-1:0] x1, x2, y1_raw, y2_raw, y1, y2, hgt;
   logic [WB-1:0]        w_size, h_size, w_lim, h_lim;
   logic                 ends_ok;
   logic [COORD_BITS-1:0] cx1, cx2, cy1, cy2, adx, ady, s_major, s_minor;
   logic signed [COORD_BITS:0] dx, dy;
   logic                 s_major_x;

   // step path
   logic signed [COORD_BITS:0] err_sub;
   logic                 diag, move_x, move_y;
   logic [COORD_BITS-1:0] dx_ext, dy_ext;

   always_comb begin
      x1     = {{EXT{item_x_start[lps_pkg::END_BITS-1]}}, item_x_start};
      x2     = {{EXT{item_x_end[lps_pkg::END_BITS-1]}}, item_x_end};
      y1_raw = {{EXT{item_y_start[lps_pkg::END_BITS-1]}}, item_y_start};
      y2_raw = {{EXT{item_y_end[lps_pkg::END_BITS-1]}}, item_y_end};
      hgt    = {{SZ_EXT{1'b0}}, cfg.fb_height};
      y1     = cfg.origin_top ? (hgt - WB'(1) - y1_raw) : y1_raw;
      y2     = cfg.origin_top ? (hgt - WB'(1) - y2_raw) : y2_raw;
      w_size = {{SZ_EXT{1'b0}}, cfg.fb_width};
      h_size = {{SZ_EXT{1'b0}}, cfg.fb_height};
      w_lim  = (w_size > LIMIT) ? LIMIT : w_size;
      h_lim  = (h_size > LIMIT) ? LIMIT : h_size;
      ends_ok = in_range(x1, w_lim) && in_range(x2, w_lim) &&
                in_range(y1, h_lim) && in_range(y2, h_lim);

      cx1 = x1[COORD_BITS-1:0];
      cx2 = x2[COORD_BITS-1:0];
      cy1 = y1[COORD_BITS-1:0];
      cy2 = y2[COORD_BITS-1:0];
      dx  = $signed({1'b0, cx2}) - $signed({1'b0, cx1});
      dy  = $signed({1'b0, cy2}) - $signed({1'b0, cy1});
      adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      s_major_x = adx > ady;
      s_major   = s_major_x ? adx : ady;
      s_minor   = s_major_x ? ady : adx;

      // error goes negative -> take the diagonal step and fold major back in
      err_sub = err_ff - $signed({1'b0, minor_ff});
      diag    = err_sub[COORD_BITS];
      move_x  = diag || major_x_ff;
      move_y  = diag || !major_x_ff;
      dx_ext  = {{(COORD_BITS-2){dir_x_ff[1]}}, dir_x_ff};
      dy_ext  = {{(COORD_BITS-2){dir_y_ff[1]}}, dir_y_ff};

      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      err_in     = err_ff;
      minor_in   = minor_ff;
      major_in   = major_ff;
      left_in    = left_ff;
      major_x_in = major_x_ff;
      dir_x_in   = dir_x_ff;
      dir_y_in   = dir_y_ff;
      color_in   = color_ff;
      active_in  = active_ff;

      res_status = lps_pkg::ST_IDLE;
      res_x      = '0;
      res_y      = '0;
      res_color  = '0;
      res_last   = 1'b0;

      if (item_func == lps_pkg::FUNC_START) begin
         active_in = 1'b0;
         if (!ends_ok) begin
            res_status = lps_pkg::ST_REJECTED;
         end else if (s_major == '0) begin
            res_status = lps_pkg::ST_EMPTY;
         end else begin
            res_status = lps_pkg::ST_ACCEPTED;
            cur_x_in   = cx1;
            cur_y_in   = cy1;
            err_in     = $signed({1'b0, s_major}) >>> 1;
            minor_in   = s_minor;
            major_in   = s_major;
            left_in    = s_major;
            major_x_in = s_major_x;
            dir_x_in   = dx[COORD_BITS] ? 2'b11 : ((dx != '0) ? 2'b01 : 2'b00);
            dir_y_in   = dy[COORD_BITS] ? 2'b11 : ((dy != '0) ? 2'b01 : 2'b00);
            color_in   = COLOR_BITS'(item_color);
            active_in  = 1'b1;
         end
      end else if (active_ff) begin
         res_status = lps_pkg::ST_PIXEL;
         res_x      = cur_x_ff;
         res_y      = cur_y_ff;
         res_color  = color_ff;
         res_last   = (left_ff == COORD_BITS'(1));
         err_in     = diag ? (err_sub + $signed({1'b0, major_ff})) : err_sub;
         cur_x_in   = move_x ? (cur_x_ff + dx_ext) : cur_x_ff;
         cur_y_in   = move_y ? (cur_y_ff + dy_ext) : cur_y_ff;
         left_in    = left_ff - COORD_BITS'(1);
         active_in  = (left_ff != COORD_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (fire) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         err_ff     <= err_in;
         minor_ff   <= minor_in;
         major_ff   <= major_in;
         left_ff    <= left_in;
         major_x_ff <= major_x_in;
         dir_x_ff   <= dir_x_in;
         dir_y_ff   <= dir_y_in;
         color_ff   <= color_in;
      end
   end

endmodule

### src/line_pixel_stepper.sv
// A word accepted into the input register moves into the result register once that register is free.
// Throughput: one word per cycle while the result side does not stall; the line state update (subtract, compare,
// increment) sits between the input register and the result register.
// Stall on the result side holds the result register and back-pressures req.
// Synchronous reset: idle, no line active, registers 320 x 240, origin bottom.
// ----------------------------------------------------------------------------
// line_pixel_stepper: top level of the Bresenham line pixel stepper
// Input register, line engine, result register and the register port.
// ----------------------------------------------------------------------------
module line_pixel_stepper #(
   parameter int COORD_BITS = 12,
   parameter int COLOR_BITS = 8
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic                                       req_func,
   input  logic signed [lps_pkg::END_BITS-1:0]        req_x_start,
   input  logic signed [lps_pkg::END_BITS-1:0]        req_y_start,
   input  logic signed [lps_pkg::END_BITS-1:0]        req_x_end,
   input  logic signed [lps_pkg::END_BITS-1:0]        req_y_end,
   input  logic [lps_pkg::COLOR_IN_BITS-1:0]          req_color,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic [lps_pkg::STATUS_BITS-1:0]            rsp_status,
   output logic [COORD_BITS-1:0]                      rsp_pixel_x,
   output logic [COORD_BITS-1:0]                      rsp_pixel_y,
   output logic [COLOR_BITS-1:0]                      rsp_pixel_color,
   output logic                                       rsp_last,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [lps_pkg::CSR_IDX_BITS-1:0]           csr_index,
   input  logic [lps_pkg::SIZE_BITS-1:0]              csr_wdata
);

   lps_pkg::lps_cfg_type cfg_ff;

   logic                                   in_valid_ff, in_valid_in;
   logic                                   in_func_ff;
   logic signed [lps_pkg::END_BITS-1:0]    in_xs_ff, in_ys_ff, in_xe_ff, in_ye_ff;
   logic [lps_pkg::COLOR_IN_BITS-1:0]      in_color_ff;

   logic                                   out_valid_ff, out_valid_in;
   logic [lps_pkg::STATUS_BITS-1:0]        out_status_ff;
   logic [COORD_BITS-1:0]                  out_x_ff, out_y_ff;
   logic [COLOR_BITS-1:0]                  out_color_ff;
   logic                                   out_last_ff;

   logic                                   out_free, fire, take;
   logic [lps_pkg::STATUS_BITS-1:0]        res_status;
   logic [COORD_BITS-1:0]                  res_x, res_y;
   logic [COLOR_BITS-1:0]                  res_color;
   logic                                   res_last;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fb_width   <= lps_pkg::FB_WIDTH_RESET;
         cfg_ff.fb_height  <= lps_pkg::FB_HEIGHT_RESET;
         cfg_ff.origin_top <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lps_pkg::CSR_FB_WIDTH:   cfg_ff.fb_width   <= csr_wdata;
            lps_pkg::CSR_FB_HEIGHT:  cfg_ff.fb_height  <= csr_wdata;
            lps_pkg::CSR_ORIGIN_TOP: cfg_ff.origin_top <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // result register frees up when empty or being taken this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = take || (in_valid_ff && !fire);
      out_valid_in = fire || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_func_ff  <= req_func;
         in_xs_ff    <= req_x_start;
         in_ys_ff    <= req_y_start;
         in_xe_ff    <= req_x_end;
         in_ye_ff    <= req_y_end;
         in_color_ff <= req_color;
      end
      if (fire) begin
         out_status_ff <= res_status;
         out_x_ff      <= res_x;
         out_y_ff      <= res_y;
         out_color_ff  <= res_color;
         out_last_ff   <= res_last;
      end
   end

   lps_engine #(
      .COORD_BITS (COORD_BITS),
      .COLOR_BITS (COLOR_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .cfg          (cfg_ff),
      .item_func    (in_func_ff),
      .item_x_start (in_xs_ff),
      .item_y_start (in_ys_ff),
      .item_x_end   (in_xe_ff),
      .item_y_end   (in_ye_ff),
      .item_color   (in_color_ff),
      .res_status   (res_status),
      .res_x        (res_x),
      .res_y        (res_y),
      .res_color    (res_color),
      .res_last     (res_last)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_last        = out_last_ff;

endmodule

### src/lps_checker.sv
// ----------------------------------------------------------------------------
// lps_checker: port-level checks for the line pixel stepper
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module lps_checker #(
   parameter int COORD_BITS = 12,
   parameter int COLOR_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [lps_pkg::STATUS_BITS-1:0]     rsp_status,
   input  logic [COORD_BITS-1:0]               rsp_pixel_x,
   input  logic [COORD_BITS-1:0]               rsp_pixel_y,
   input  logic [COLOR_BITS-1:0]               rsp_pixel_color,
   input  logic                                rsp_last
);

   // non-pixel words carry zero fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != lps_pkg::ST_PIXEL) |->
         (rsp_pixel_x == '0 && rsp_pixel_y == '0 &&
          rsp_pixel_color == '0 && !rsp_last))
      else $error("non-pixel word with nonzero fields");

   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_status == lps_pkg::ST_PIXEL))
      else $error("last flag on a non-pixel word");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   // a new word needs an earlier accepted input word or an input word held by a stall
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && !$past(reset, 2) && !$past(reset)) |->
         $past(req_valid && !req_stall, 2) || $past(req_stall))
      else $error("result word without an input word");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
                                    $stable(rsp_pixel_x) && $stable(rsp_pixel_y)))
      else $error("stalled result word changed");

endmodule

bind line_pixel_stepper lps_checker #(
   .COORD_BITS (COORD_BITS),
   .COLOR_BITS (COLOR_BITS)
) u_lps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_last        (rsp_last)
);
